// File: hw/rtl/lcsnb_pkg.sv
// ----------------------------------------------------------------------------
// lcsnb_pkg
// Shared types, constants and helpers for the counting-sort engine with its
// built-in linear congruential generator.
// ----------------------------------------------------------------------------
package lcsnb_pkg;

    // Default number of value bits (bins = 2**VALUE_BITS)
    localparam int VALUE_BITS_DEF = 6;

    // Fixed field widths of the item channels
    localparam int OP_W      = 2;
    localparam int BIN_IDX_W = 6;
    localparam int OUT_VAL_W = 6;
    localparam int COUNT_W   = 4;

    // Generator
    localparam int          GEN_W   = 31;
    localparam logic [30:0] LCG_MUL = 31'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SEED_IDX_W = 3;
    localparam int RANK_OFS_W = 10;
    localparam int SKIP_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED_INDEX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_INTERVAL = 2'd2;

    // Operation codes of the input item
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_GEN   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Generator control from the sequencer
    typedef struct packed {
        logic load;  // load a new seed
        logic mul;   // register state * multiplier
        logic add;   // state <= product + increment
    } t_lcg_ctrl;

    // Seed table; indices past the end saturate to the last seed
    function automatic logic [31:0] seed_lookup(input logic [SEED_IDX_W-1:0] idx);
        logic [31:0] s;
        unique case (idx)
            3'd0:    s = 32'h1234abcd;
            3'd1:    s = 32'h10203040;
            3'd2:    s = 32'h40e8c724;
            3'd3:    s = 32'h79cbba1d;
            default: s = 32'hac7bd459;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/lcsnb_in_if.sv
// ----------------------------------------------------------------------------
// lcsnb_in_if
// Input item channel: valid/ready handshake with operation and bin index.
// ----------------------------------------------------------------------------
interface lcsnb_in_if;
    import lcsnb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [BIN_IDX_W-1:0] bin_index;

    modport source (output valid, output operation, output bin_index, input ready);
    modport sink   (input valid, input operation, input bin_index, output ready);
endinterface

// File: hw/rtl/lcsnb_out_if.sv
// ----------------------------------------------------------------------------
// lcsnb_out_if
// Result item channel: valid/ready handshake with value, overflow and last.
// ----------------------------------------------------------------------------
interface lcsnb_out_if;
    import lcsnb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_VAL_W-1:0] value;
    logic                 overflow;
    logic                 last;

    modport source (output valid, output value, output overflow, output last, input ready);
    modport sink   (input valid, input value, input overflow, input last, output ready);
endinterface

// File: hw/rtl/lcsnb_bin_mem.sv
// ----------------------------------------------------------------------------
// lcsnb_bin_mem
// Bin count store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lcsnb_bin_mem #(
    parameter int ADDR_W = lcsnb_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [lcsnb_pkg::COUNT_W-1:0] o_rd_data,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [lcsnb_pkg::COUNT_W-1:0] i_wr_data
);
    import lcsnb_pkg::*;

    logic [COUNT_W-1:0] r_mem [2**ADDR_W];
    logic [COUNT_W-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: hw/rtl/lcsnb_lcg.sv
// ----------------------------------------------------------------------------
// lcsnb_lcg
// 31-bit linear congruential generator, stepped by first multiplying
// into a product register, then adding the increment.
// ----------------------------------------------------------------------------
module lcsnb_lcg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcsnb_pkg::t_lcg_ctrl       i_ctrl,
    input  logic [lcsnb_pkg::GEN_W-1:0] i_seed,
    output logic [lcsnb_pkg::GEN_W-1:0] o_state
);
    import lcsnb_pkg::*;

    logic [GEN_W-1:0] r_state;
    logic [GEN_W-1:0] r_prod;

    // Generator state: seed load or product plus increment, mod 2**31
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_ctrl.load) begin
            r_state <= i_seed;
        end else if (i_ctrl.add) begin
            r_state <= r_prod + LCG_ADD;
        end
    end

    // Low 31 bits of the product
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= r_state * LCG_MUL;
        end
    end

    assign o_state = r_state;
endmodule

// File: hw/rtl/lcg_counting_sort_nibble_bins.sv
// ----------------------------------------------------------------------------
// lcg_counting_sort_nibble_bins
// Counting-sort engine: 4-bit bins in a synchronous memory, fed by a
// built-in 31-bit linear congruential generator, read out with a skip filter.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the input is ready only while the
// sequencer is idle, and results go through a one-item output register.
// A generate item runs through multiply, add, bin read and bin write with
// its result. A readout item reads the bin, then steps through each copy
// of the bin's value (at most 15), and does nothing when the skip interval
// is 0. A start item clears the bin memory one entry per cycle. The same
// clearing pass runs after reset over all 2**VALUE_BITS entries (64 at the
// default) before the first item is accepted. Configuration writes are
// taken in any cycle. Emitting a result waits while the output register
// is full and not being taken.
// ----------------------------------------------------------------------------
module lcg_counting_sort_nibble_bins #(
    parameter int VALUE_BITS = lcsnb_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lcsnb_in_if.sink                         i_in,
    lcsnb_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [lcsnb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcsnb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcsnb_pkg::*;

    localparam int ADDR_W = VALUE_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GEN_ADD,
        S_GEN_RD,
        S_GEN_WR,
        S_RD_LOAD,
        S_RD_STEP
    } t_state;

    // Configuration registers
    logic [SEED_IDX_W-1:0] r_seed_index;
    logic [RANK_OFS_W-1:0] r_rank_offset;
    logic [SKIP_W-1:0]     r_skip_interval;

    // Sequencer state
    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic [SKIP_W-1:0]     r_skip_cnt, n_skip_cnt;
    logic [COUNT_W-1:0]    r_left, n_left;
    logic                  r_pend, n_pend;
    logic [OUT_VAL_W-1:0]  r_bin, n_bin;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic [OUT_VAL_W-1:0]  r_out_value, n_out_value;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    // Datapath signals
    t_lcg_ctrl             lcg_ctrl;
    logic [GEN_W-1:0]      lcg_state;
    logic [GEN_W-1:0]      seed;
    logic [31:0]           seed_word;
    logic [GEN_W-1:0]      seed_sum;
    logic [SEED_IDX_W-1:0] seed_sel;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [COUNT_W-1:0]    mem_rd_data;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic [COUNT_W-1:0]    mem_wr_data;
    logic [COUNT_W-1:0]    cnt_inc;
    logic [ADDR_W-1:0]     gen_bin;
    logic [ADDR_W-1:0]     rd_bin;
    logic [ADDR_W+BIN_IDX_W-1:0] rd_bin_ext;
    logic [ADDR_W+OUT_VAL_W-1:0] rd_val_ext;
    logic [ADDR_W+OUT_VAL_W-1:0] gen_val_ext;
    logic [SKIP_W-1:0]     skip_inc;
    logic [SKIP_W-1:0]     skip_next;
    logic                  slot_free;
    logic                  in_acc;

    // Bin store and generator
    lcsnb_bin_mem #(
        .ADDR_W (ADDR_W)
    ) u_bin_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    lcsnb_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lcg_ctrl),
        .i_seed  (seed),
        .o_state (lcg_state)
    );

    // Seed: table entry plus rank offset, low 31 bits, zero forced to one
    assign seed_sel  = (r_seed_index > SEED_IDX_W'(4)) ? SEED_IDX_W'(4) : r_seed_index;
    assign seed_word = seed_lookup(seed_sel);
    assign seed_sum  = seed_word[GEN_W-1:0] + GEN_W'(r_rank_offset);
    assign seed      = (seed_sum == '0) ? GEN_W'(1) : seed_sum;

    // Bin addresses and values
    assign gen_bin     = lcg_state[ADDR_W-1:0];
    assign gen_val_ext = {{OUT_VAL_W{1'b0}}, gen_bin};
    assign rd_bin_ext  = {{ADDR_W{1'b0}}, i_in.bin_index};
    assign rd_bin      = rd_bin_ext[ADDR_W-1:0];
    assign rd_val_ext  = {{OUT_VAL_W{1'b0}}, rd_bin};
    assign cnt_inc     = mem_rd_data + COUNT_W'(1);

    // Skip counter advance, wrapping at the interval
    assign skip_inc  = r_skip_cnt + SKIP_W'(1);
    assign skip_next = (skip_inc == r_skip_interval) ? '0 : skip_inc;

    assign slot_free = !r_out_valid || o_out.ready;
    assign in_acc    = i_in.valid && (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_skip_cnt  = r_skip_cnt;
        n_left      = r_left;
        n_pend      = r_pend;
        n_bin       = r_bin;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        lcg_ctrl    = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_bin;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_clr_addr;
        mem_wr_data = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en  = 1'b1;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.operation)
                        OP_START: begin
                            lcg_ctrl.load = 1'b1;
                            n_skip_cnt    = '0;
                            n_clr_addr    = '0;
                            n_state       = S_CLEAR;
                        end
                        OP_GEN: begin
                            lcg_ctrl.mul = 1'b1;
                            n_state      = S_GEN_ADD;
                        end
                        OP_READ: begin
                            if (r_skip_interval != '0) begin
                                mem_rd_en = 1'b1;
                                n_bin     = rd_val_ext[OUT_VAL_W-1:0];
                                n_state   = S_RD_LOAD;
                            end
                        end
                        default: begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            S_GEN_ADD: begin
                lcg_ctrl.add = 1'b1;
                n_state      = S_GEN_RD;
            end
            S_GEN_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = gen_bin;
                n_state     = S_GEN_WR;
            end
            S_GEN_WR: begin
                // write back the count together with its result
                if (slot_free) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = gen_bin;
                    mem_wr_data = cnt_inc;
                    n_out_valid = 1'b1;
                    n_out_value = gen_val_ext[OUT_VAL_W-1:0];
                    n_out_ovf   = (cnt_inc == '0);
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD_LOAD: begin
                n_left  = mem_rd_data;
                n_pend  = 1'b0;
                n_state = S_RD_STEP;
            end
            S_RD_STEP: begin
                if (r_left == '0) begin
                    // flush the held emission as the final result
                    if (!r_pend) begin
                        n_state = S_IDLE;
                    end else if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out_value = r_bin;
                        n_out_ovf   = 1'b0;
                        n_out_last  = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (!(r_skip_cnt == '0 && r_pend && !slot_free)) begin
                    // advance one copy; push the held emission if a new one comes
                    if (r_skip_cnt == '0) begin
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out_value = r_bin;
                            n_out_ovf   = 1'b0;
                            n_out_last  = 1'b0;
                        end
                        n_pend = 1'b1;
                    end
                    n_skip_cnt = skip_next;
                    n_left     = r_left - COUNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_skip_cnt  <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_skip_cnt  <= n_skip_cnt;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bin       <= n_bin;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
        r_out_last  <= n_out_last;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_index    <= '0;
            r_rank_offset   <= '0;
            r_skip_interval <= SKIP_W'(1);
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                CFG_SEED_INDEX:    r_seed_index    <= i_cfg_data[SEED_IDX_W-1:0];
                CFG_RANK_OFFSET:   r_rank_offset   <= i_cfg_data[RANK_OFS_W-1:0];
                CFG_SKIP_INTERVAL: r_skip_interval <= i_cfg_data[SKIP_W-1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // Channel ports
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_out_value;
    assign o_out.overflow = r_out_ovf;
    assign o_out.last     = r_out_last;
endmodule

// File: tb/tb_lcg_counting_sort_nibble_bins.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcg_counting_sort_nibble_bins
// Self-checking bench for the counting-sort engine. A bit-true software copy
// of the generator, the 4-bit bin tallies and the skip filter predicts every
// result item, and each item leaving the block is checked field by field
// against the oldest prediction. Directed items hit the corners, a fill
// spreads generated values over the bins and every bin is read back, and
// random start, generate and readout sequences follow under changing
// register settings. The input side sends in bursts with gaps, and the
// output side stalls in shifting patterns.
// ----------------------------------------------------------------------------
module tb_lcg_counting_sort_nibble_bins;
    import lcsnb_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int RST_CYCLES = 11;
    localparam int DRAIN_WAIT = 80;    // covers a start item's clearing pass
    localparam int QUIET_MAX  = 4000;
    localparam int FILL_GENS  = 48;
    localparam int RAND_ITEMS = 50;
    localparam int NUM_BINS   = 64;
    localparam int MAX_REPORTS = 10;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] value;
        logic                 overflow;
        logic                 last;
    } t_emission;

    typedef enum int {
        TAKE_ALL,
        TAKE_HALF,
        TAKE_RARE,
        TAKE_CYCLIC
    } t_stall_mode;

    // Bin tally predictor and store of expected result items
    class tally_scoreboard;
        logic [SEED_IDX_W-1:0] seed_sel;
        logic [RANK_OFS_W-1:0] rank_ofs;
        logic [SKIP_W-1:0]     skip_n;
        logic [GEN_W-1:0]      lcg_state;
        logic [COUNT_W-1:0]    bin_tally [NUM_BINS];
        logic [SKIP_W-1:0]     skip_count;
        logic [OUT_VAL_W-1:0]  last_value;
        t_emission             emissions_due [$];
        int unsigned           fail_count;

        function new();
            seed_sel   = '0;
            rank_ofs   = '0;
            skip_n     = 16'd1;
            lcg_state  = '0;
            skip_count = '0;
            last_value = '0;
            fail_count = 0;
            foreach (bin_tally[b]) bin_tally[b] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SEED_INDEX:    seed_sel = data[SEED_IDX_W-1:0];
                CFG_RANK_OFFSET:   rank_ofs = data[RANK_OFS_W-1:0];
                CFG_SKIP_INTERVAL: skip_n   = data[SKIP_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return emissions_due.size();
        endfunction

        // Advance the model by one accepted input item
        function void note_item(logic [OP_W-1:0] op, logic [BIN_IDX_W-1:0] bin);
            logic [31:0]        seed;
            longint unsigned    product;
            logic [COUNT_W-1:0] tally;
            int                 kept;
            t_emission          e;
            case (op)
                OP_START: begin
                    // indices past the end of the table saturate to the last seed
                    case (seed_sel)
                        3'd0:    seed = 32'h1234abcd;
                        3'd1:    seed = 32'h10203040;
                        3'd2:    seed = 32'h40e8c724;
                        3'd3:    seed = 32'h79cbba1d;
                        default: seed = 32'hac7bd459;
                    endcase
                    seed = seed + 32'(rank_ofs);
                    lcg_state = (seed[GEN_W-1:0] == '0) ? 31'd1 : seed[GEN_W-1:0];
                    foreach (bin_tally[b]) bin_tally[b] = '0;
                    skip_count = '0;
                end
                OP_GEN: begin
                    product    = 64'(lcg_state) * 64'd1103515245 + 64'd12345;
                    lcg_state  = product[GEN_W-1:0];
                    last_value = lcg_state[OUT_VAL_W-1:0];
                    tally      = bin_tally[last_value] + 4'd1;
                    bin_tally[last_value] = tally;
                    e.value    = last_value;
                    e.overflow = (tally == '0);
                    e.last     = 1'b1;
                    emissions_due.push_back(e);
                end
                OP_READ: begin
                    // zero interval: nothing comes out and the counter holds
                    kept = 0;
                    if (skip_n != '0) begin
                        for (int j = 0; j < int'(bin_tally[bin]); j++) begin
                            if (skip_count == '0) begin
                                e.value    = bin;
                                e.overflow = 1'b0;
                                e.last     = 1'b0;
                                emissions_due.push_back(e);
                                kept++;
                            end
                            skip_count = skip_count + 16'd1;
                            if (skip_count == skip_n) skip_count = '0;
                        end
                    end
                    // flag the final item of this readout
                    if (kept > 0) begin
                        e      = emissions_due.pop_back();
                        e.last = 1'b1;
                        emissions_due.push_back(e);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result item with the oldest prediction
        function void check_result(logic [OUT_VAL_W-1:0] value, logic overflow, logic last);
            t_emission want;
            if (emissions_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] unexpected item: value=%0d overflow=%b last=%b",
                             $time, value, overflow, last);
                return;
            end
            want = emissions_due.pop_front();
            if (value !== want.value || overflow !== want.overflow || last !== want.last) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] mismatch: expected value=%0d overflow=%b last=%b, %s%0d %s%b %s%b",
                             $time, want.value, want.overflow, want.last,
                             "got value=", value, "overflow=", overflow, "last=", last);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lcsnb_in_if  in_if ();
    lcsnb_out_if out_if ();

    tally_scoreboard tally_sb;
    int burst_left   = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;

    lcg_counting_sort_nibble_bins u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Check every result item taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            tally_sb.check_result(out_if.value, out_if.overflow, out_if.last);
    end

    // Count cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Abort a run that has stopped moving
    initial begin
        while (quiet_cycles < QUIET_MAX) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // Stall the output side in stretches of changing pattern
    initial begin
        t_stall_mode mode;
        int          mode_left;
        mode      = TAKE_ALL;
        mode_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 90);
            end
            mode_left--;
            case (mode)
                TAKE_ALL:  out_if.ready <= 1'b1;
                TAKE_HALF: out_if.ready <= ($urandom_range(0, 1) == 1);
                TAKE_RARE: out_if.ready <= ($urandom_range(0, 4) == 0);
                default:   out_if.ready <= (mode_left % 3 != 0);
            endcase
        end
    end

    // Send one input item, opening a new burst after a random gap
    task automatic put_item(input logic [OP_W-1:0] op, input logic [BIN_IDX_W-1:0] bin);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.bin_index <= bin;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        tally_sb.note_item(op, bin);
        items_sent++;
    endtask

    // Hold input until every expected item is out, then let the block settle
    task automatic drain_and_pause();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (tally_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write all three registers back to back; unused data bits carry noise
    task automatic program_regs(input logic [SEED_IDX_W-1:0] seed_sel,
                                input logic [RANK_OFS_W-1:0] rank,
                                input logic [SKIP_W-1:0]     skip);
        logic [31:0]           junk;
        logic [CFG_DATA_W-1:0] seed_word;
        logic [CFG_DATA_W-1:0] rank_word;
        junk      = $urandom;
        seed_word = {junk[12:0], seed_sel};
        rank_word = {junk[21:16], rank};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SEED_INDEX;
        i_cfg_data  <= seed_word;
        tally_sb.write_reg(CFG_SEED_INDEX, seed_word);
        @(posedge i_clk);
        i_cfg_index <= CFG_RANK_OFFSET;
        i_cfg_data  <= rank_word;
        tally_sb.write_reg(CFG_RANK_OFFSET, rank_word);
        @(posedge i_clk);
        i_cfg_index <= CFG_SKIP_INTERVAL;
        i_cfg_data  <= skip;
        tally_sb.write_reg(CFG_SKIP_INTERVAL, skip);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int                    rand_base;
        int                    gens;
        logic [SKIP_W-1:0]     skip;
        logic [RANK_OFS_W-1:0] rank;

        tally_sb = new();
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_START;
        in_if.bin_index <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_SEED_INDEX;
        i_cfg_data      <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Saturated seed index, top rank offset; generate before any start
        program_regs(3'd7, 10'h3FF, 16'd1);
        put_item(OP_GEN, 6'd0);
        put_item(OP_READ, 6'd0);
        put_item(OP_UNUSED, 6'h3F);
        put_item(OP_START, 6'h2A);
        repeat (5) put_item(OP_GEN, 6'($urandom_range(0, 63)));
        put_item(OP_READ, 6'd0);
        put_item(OP_READ, 6'h3F);
        repeat (3) put_item(OP_READ, tally_sb.last_value);

        // Zero interval: readouts give nothing and leave the counter alone
        drain_and_pause();
        program_regs(3'd0, 10'd0, 16'd0);
        put_item(OP_READ, tally_sb.last_value);
        put_item(OP_READ, 6'h3F);
        put_item(OP_GEN, 6'h15);

        // Widest interval: only the first emission after start survives
        drain_and_pause();
        program_regs(3'd5, 10'd0, 16'hFFFF);
        put_item(OP_START, 6'd0);
        repeat (3) put_item(OP_GEN, 6'($urandom_range(0, 63)));
        repeat (3) put_item(OP_READ, tally_sb.last_value);

        // Fill: spread generated values over the bins, then read every bin
        drain_and_pause();
        program_regs(3'd1, 10'd0, 16'd1);
        put_item(OP_START, 6'd0);
        repeat (FILL_GENS) put_item(OP_GEN, 6'($urandom_range(0, 63)));
        for (int b = 0; b < NUM_BINS; b++) put_item(OP_READ, 6'(b));

        // Build up the skip counter, then drop the interval below it
        drain_and_pause();
        program_regs(3'd1, 10'd0, 16'd200);
        repeat (12) put_item(OP_READ, 6'($urandom_range(0, 63)));
        drain_and_pause();
        program_regs(3'd2, 10'd0, 16'd3);
        repeat (4) put_item(OP_READ, 6'($urandom_range(0, 63)));

        // Random sequences: mostly start, generate, readout, with some noise
        rand_base = items_sent;
        while (items_sent < rand_base + RAND_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                drain_and_pause();
                case ($urandom_range(0, 9))
                    0:       skip = 16'd0;
                    1:       skip = 16'hFFFF;
                    2:       skip = 16'($urandom);
                    3, 4:    skip = 16'($urandom_range(5, 20));
                    default: skip = 16'($urandom_range(1, 4));
                endcase
                case ($urandom_range(0, 3))
                    0:       rank = '0;
                    1:       rank = 10'h3FF;
                    default: rank = 10'($urandom);
                endcase
                program_regs(3'($urandom_range(0, 7)), rank, skip);
            end
            if ($urandom_range(0, 3) != 0) put_item(OP_START, 6'($urandom_range(0, 63)));
            gens = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 100) : $urandom_range(1, 24);
            repeat (gens) put_item(OP_GEN, 6'($urandom_range(0, 63)));
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1) == 0)
                    put_item(OP_READ, tally_sb.last_value);
                else
                    put_item(OP_READ, 6'($urandom_range(0, 63)));
            end
            if ($urandom_range(0, 3) == 0)
                put_item(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
        end

        drain_and_pause();
        if (tally_sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
